// File: rtl/core/dpes_pkg.sv
// ----------------------------------------------------------------------------
// dpes_pkg
// shared types and defaults for the descending pair exchange sort core
// ----------------------------------------------------------------------------
`default_nettype none

package dpes_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int KEY_FIELD_W     = 16;
    localparam int TAG_W           = 16;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] sort_key;
        logic [TAG_W-1:0]       payload_tag;
        logic                   set_last;
    } dpes_item_t;

    typedef struct packed {
        logic [KEY_FIELD_W-1:0] out_key;
        logic [TAG_W-1:0]       out_tag;
        logic                   out_last;
        logic                   overflowed;
    } dpes_result_t;

endpackage

`default_nettype wire

// File: rtl/core/dpes_store.sv
// ----------------------------------------------------------------------------
// dpes_store
// pair memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module dpes_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/dpes_ctrl.sv
// ----------------------------------------------------------------------------
// dpes_ctrl
// load, exchange-sort and emit sequencer around the pair memory
// ----------------------------------------------------------------------------
`default_nettype none

module dpes_ctrl #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire dpes_pkg::dpes_item_t  item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output dpes_pkg::dpes_result_t     result,
    // memory port
    output logic                       mem_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0] mem_wr_addr,
    output logic [((KEY_BITS < dpes_pkg::KEY_FIELD_W) ? KEY_BITS : dpes_pkg::KEY_FIELD_W)
                  + dpes_pkg::TAG_W - 1:0] mem_wr_data,
    output logic                       mem_rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0] mem_rd_addr,
    input  wire logic [((KEY_BITS < dpes_pkg::KEY_FIELD_W) ? KEY_BITS : dpes_pkg::KEY_FIELD_W)
                  + dpes_pkg::TAG_W - 1:0] mem_rd_data
);

    import dpes_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int DW = KW + TAG_W;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FETCH,
        ST_PRIME,
        ST_SCAN,
        ST_STORE,
        ST_EMIT_RD,
        ST_EMIT_CAP
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  fill_reg;
    logic           ovf_reg;
    logic [AW-1:0]  i_reg;
    logic [AW-1:0]  j_reg;
    logic [AW-1:0]  last_idx_reg;
    logic [DW-1:0]  cur_reg;
    logic           result_valid_reg;
    dpes_result_t   result_reg;

    logic           full;
    logic           take;
    logic           swap;
    logic           scan_end;
    logic           pass_end;
    logic           out_free;
    logic [DW-1:0]  item_word;

    assign full      = (fill_reg == CW'(MAX_ENTRIES));
    assign take      = item_valid && (state_reg == ST_LOAD);
    assign swap      = cur_reg[DW-1:TAG_W] < mem_rd_data[DW-1:TAG_W];
    assign scan_end  = (j_reg == last_idx_reg);
    assign pass_end  = ((i_reg + AW'(1)) == last_idx_reg);
    assign out_free  = !result_valid_reg || result_ready;
    assign item_word = {item.sort_key[KW-1:0], item.payload_tag};

    assign item_ready   = (state_reg == ST_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // memory request per state
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = j_reg;
        mem_wr_data = cur_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = i_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                mem_wr_en   = take && !full;
                mem_wr_addr = fill_reg[AW-1:0];
                mem_wr_data = item_word;
            end
            ST_FETCH:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = i_reg;
            end
            ST_PRIME:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = j_reg;
            end
            ST_SCAN:
            begin
                mem_wr_en   = swap;
                mem_wr_addr = j_reg;
                mem_rd_en   = !scan_end;
                mem_rd_addr = j_reg + AW'(1);
            end
            ST_STORE:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = i_reg;
                mem_rd_en   = !pass_end;
                mem_rd_addr = i_reg + AW'(1);
            end
            ST_EMIT_RD:
            begin
                mem_rd_en   = out_free;
                mem_rd_addr = j_reg;
            end
            ST_EMIT_CAP:
            begin
                mem_rd_en = 1'b0;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            fill_reg         <= '0;
            ovf_reg          <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            last_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (take)
                    begin
                        if (full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                        if (item.set_last)
                        begin
                            last_idx_reg <= full ? AW'(MAX_ENTRIES - 1) : fill_reg[AW-1:0];
                            i_reg        <= '0;
                            j_reg        <= '0;
                            // a single pair needs no sorting
                            if (!full && fill_reg == '0)
                            begin
                                state_reg <= ST_EMIT_RD;
                            end
                            else
                            begin
                                state_reg <= ST_FETCH;
                            end
                        end
                    end
                end
                ST_FETCH:
                begin
                    j_reg     <= i_reg + AW'(1);
                    state_reg <= ST_PRIME;
                end
                ST_PRIME:
                begin
                    cur_reg   <= mem_rd_data;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    // keep the larger key in the holding register
                    if (swap)
                    begin
                        cur_reg <= mem_rd_data;
                    end
                    if (scan_end)
                    begin
                        state_reg <= ST_STORE;
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1);
                    end
                end
                ST_STORE:
                begin
                    if (pass_end)
                    begin
                        j_reg     <= '0;
                        state_reg <= ST_EMIT_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + AW'(1);
                        j_reg     <= i_reg + AW'(2);
                        state_reg <= ST_PRIME;
                    end
                end
                ST_EMIT_RD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_EMIT_CAP;
                    end
                end
                ST_EMIT_CAP:
                begin
                    result_valid_reg      <= 1'b1;
                    result_reg.out_key    <= KEY_FIELD_W'(mem_rd_data[DW-1:TAG_W]);
                    result_reg.out_tag    <= mem_rd_data[TAG_W-1:0];
                    result_reg.out_last   <= scan_end;
                    result_reg.overflowed <= ovf_reg;
                    if (scan_end)
                    begin
                        fill_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        j_reg     <= j_reg + AW'(1);
                        state_reg <= ST_EMIT_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_ENTRIES))
        else $error("fill count above capacity");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("read and write of the same entry in one cycle");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (j_reg > i_reg && j_reg <= last_idx_reg))
        else $error("scan index outside the current pass");

    a_out_free_on_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_CAP) |-> !result_valid_reg)
        else $error("output register overwritten before transfer");
`endif

endmodule

`default_nettype wire

// File: rtl/core/descending_pair_exchange_sort_core.sv
// sequencing: a set of n pairs loads at one pair per cycle while the core is in its load
//   state; the sort then runs n-1 passes with one compare unit and one memory read port
// output: each sorted pair takes a memory read, then a capture; the read is held
//   while the output register still holds a pair that has not been taken
// reset: asynchronous, clears the fill count, overflow flag, sequencer and output valid;
//   the pair memory is not cleared, only written entries are ever read
// ----------------------------------------------------------------------------
// descending_pair_exchange_sort_core
// collects (key, tag) pairs, exchange-sorts them by key in descending order in
// place in a pair memory, then streams the sorted pairs out
// ----------------------------------------------------------------------------
`default_nettype none

module descending_pair_exchange_sort_core #(
    parameter int MAX_ENTRIES = dpes_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = dpes_pkg::KEY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input pairs, one transfer per pair
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire dpes_pkg::dpes_item_t  item,
    // sorted pairs, one transfer per pair
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output dpes_pkg::dpes_result_t     result
);

    import dpes_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int DW = KW + TAG_W;

    // memory port between sequencer and pair store
    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [DW-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [DW-1:0] mem_rd_data;

    // sequencer: load, in-place exchange sort with one held element, emit
    dpes_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // key and tag of each pair share one memory word
    dpes_store #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (DW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

`default_nettype wire
